@@ hdl/ddm_pkg.sv @@
package ddm_pkg;

    localparam int STICK_WIDTH = 10;

    localparam int IN_BITS     = 2 * STICK_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_MAG_W   = 11;
    localparam int OUT_BITS    = 2 * OUT_MAG_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int DEADBAND_W  = 9;
    localparam int GAIN_W      = 4;
    localparam int OFFSET_W    = 9;
    localparam int LIMIT_W     = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE_DEADBAND = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_DEADBAND     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE_GAIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE_OFFSET   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT       = 3'd4;

    localparam logic [DEADBAND_W-1:0] RST_THROTTLE_DEADBAND = 9'd20;
    localparam logic [DEADBAND_W-1:0] RST_TURN_DEADBAND     = 9'd10;
    localparam logic [GAIN_W-1:0]     RST_THROTTLE_GAIN     = 4'd7;
    localparam logic [OFFSET_W-1:0]   RST_THROTTLE_OFFSET   = 9'd150;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT       = 10'd512;

    localparam int MAG_W    = STICK_WIDTH;
    localparam int DB_CMP_W = (MAG_W > DEADBAND_W) ? MAG_W : DEADBAND_W;
    localparam int PROD_W   = MAG_W + GAIN_W;

    // divide by ten as multiply by reciprocal
    localparam int DIV10_SHIFT = PROD_W + 4;
    localparam int DIV10_MUL_W = DIV10_SHIFT - 3;
    localparam int DIV10_MUL   = (2 ** DIV10_SHIFT + 9) / 10;
    localparam int DIVP_W      = PROD_W + DIV10_MUL_W;
    localparam int DIV_W       = DIVP_W - DIV10_SHIFT;

    localparam int THR_W    = STICK_WIDTH + 2;
    localparam int SIDE_W   = STICK_WIDTH + 2;
    localparam int SSIDE_W  = SIDE_W + 1;
    localparam int SPROD_W  = SIDE_W + LIMIT_W;
    localparam int NUM_W    = SPROD_W + 2;
    localparam int REM_W    = SIDE_W + 1;
    localparam int Q_W      = LIMIT_W;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;
    localparam int NSTAGE         = 6 + DIV_STAGES + 1;

    typedef struct packed {
        logic                 lfwd;
        logic                 rfwd;
        logic [OUT_MAG_W-1:0] lmag;
        logic [OUT_MAG_W-1:0] rmag;
        logic                 scale;
        logic                 left_big;
    } side_t;

endpackage

@@ hdl/differential_drive_mixer.sv @@
// differential drive mixer, fully pipelined
// throughput: one sample per cycle while the result side does not stall; the limit scaling divider retires
// two quotient bits per stage over five stages
// a stall on the result side holds every stage in place
// reset (aresetn low, synchronous) empties the pipeline and loads register defaults
module differential_drive_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ddm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ddm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // turn_position, throttle_position, zero pad
    input  logic [ddm_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_magnitude, right_magnitude, left_forward, right_forward
    output logic [ddm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int SW = ddm_pkg::STICK_WIDTH;
    localparam int DS = ddm_pkg::DIV_STAGES;

    logic [ddm_pkg::DEADBAND_W-1:0] thr_db_reg;
    logic [ddm_pkg::DEADBAND_W-1:0] turn_db_reg;
    logic [ddm_pkg::GAIN_W-1:0]     gain_reg;
    logic [ddm_pkg::OFFSET_W-1:0]   offset_reg;
    logic [ddm_pkg::LIMIT_W-1:0]    limit_reg;

    logic                        adv;
    logic [ddm_pkg::NSTAGE-1:0]  valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_db_reg  <= ddm_pkg::RST_THROTTLE_DEADBAND;
            turn_db_reg <= ddm_pkg::RST_TURN_DEADBAND;
            gain_reg    <= ddm_pkg::RST_THROTTLE_GAIN;
            offset_reg  <= ddm_pkg::RST_THROTTLE_OFFSET;
            limit_reg   <= ddm_pkg::RST_SPEED_LIMIT;
        end else if (cfg_we) begin
            case (cfg_index)
                ddm_pkg::CFG_THROTTLE_DEADBAND: thr_db_reg  <= cfg_data[ddm_pkg::DEADBAND_W-1:0];
                ddm_pkg::CFG_TURN_DEADBAND:     turn_db_reg <= cfg_data[ddm_pkg::DEADBAND_W-1:0];
                ddm_pkg::CFG_THROTTLE_GAIN:     gain_reg    <= cfg_data[ddm_pkg::GAIN_W-1:0];
                ddm_pkg::CFG_THROTTLE_OFFSET:   offset_reg  <= cfg_data[ddm_pkg::OFFSET_W-1:0];
                ddm_pkg::CFG_SPEED_LIMIT:       limit_reg   <= cfg_data[ddm_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !valid_reg[ddm_pkg::NSTAGE-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[ddm_pkg::NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[ddm_pkg::NSTAGE-2:0], s_tvalid};
        end
    end

    // stage 1: re-centre, deadband, throttle gain product
    logic [SW-1:0]                   turn_bits;
    logic [SW-1:0]                   thr_bits;
    logic [ddm_pkg::MAG_W-1:0]       turn_mag;
    logic [ddm_pkg::MAG_W-1:0]       thr_mag;
    logic                            turn_zero;
    logic                            thr_zero;
    logic [SW-1:0]                   turn_s1_reg;
    logic                            thr_neg_s1_reg;
    logic                            thr_nz_s1_reg;
    logic [ddm_pkg::PROD_W-1:0]      prod_s1_reg;

    assign turn_bits = {~s_tdata[SW-1], s_tdata[SW-2:0]};
    assign thr_bits  = {~s_tdata[2*SW-1], s_tdata[2*SW-2:SW]};
    assign turn_mag  = turn_bits[SW-1] ? (~turn_bits + SW'(1)) : turn_bits;
    assign thr_mag   = thr_bits[SW-1] ? (~thr_bits + SW'(1)) : thr_bits;
    assign turn_zero = ddm_pkg::DB_CMP_W'(turn_mag) < ddm_pkg::DB_CMP_W'(turn_db_reg);
    assign thr_zero  = ddm_pkg::DB_CMP_W'(thr_mag) < ddm_pkg::DB_CMP_W'(thr_db_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            turn_s1_reg    <= turn_zero ? '0 : turn_bits;
            thr_neg_s1_reg <= thr_bits[SW-1];
            thr_nz_s1_reg  <= !thr_zero && (thr_mag != '0);
            prod_s1_reg    <= ddm_pkg::PROD_W'(thr_mag) * ddm_pkg::PROD_W'(gain_reg);
        end
    end

    // stage 2: divide by ten
    logic [ddm_pkg::DIVP_W-1:0] div_full;
    logic [SW-1:0]              turn_s2_reg;
    logic                       thr_neg_s2_reg;
    logic                       thr_nz_s2_reg;
    logic [ddm_pkg::DIV_W-1:0]  div_s2_reg;

    assign div_full = ddm_pkg::DIVP_W'(prod_s1_reg) * ddm_pkg::DIVP_W'(ddm_pkg::DIV10_MUL);

    always_ff @(posedge aclk) begin
        if (adv) begin
            turn_s2_reg    <= turn_s1_reg;
            thr_neg_s2_reg <= thr_neg_s1_reg;
            thr_nz_s2_reg  <= thr_nz_s1_reg;
            div_s2_reg     <= div_full[ddm_pkg::DIVP_W-1:ddm_pkg::DIV10_SHIFT];
        end
    end

    // stage 3: offset and mixing
    logic [ddm_pkg::THR_W-1:0]          thr_m;
    logic                               rev;
    logic signed [ddm_pkg::SSIDE_W-1:0] m_s;
    logic signed [ddm_pkg::SSIDE_W-1:0] turn_ext;
    logic signed [ddm_pkg::SSIDE_W-1:0] left_next;
    logic signed [ddm_pkg::SSIDE_W-1:0] right_next;
    logic signed [ddm_pkg::SSIDE_W-1:0] left_s3_reg;
    logic signed [ddm_pkg::SSIDE_W-1:0] right_s3_reg;

    assign thr_m    = thr_nz_s2_reg ?
                      (ddm_pkg::THR_W'(div_s2_reg) + ddm_pkg::THR_W'(offset_reg)) : '0;
    assign rev      = thr_neg_s2_reg && (thr_m != '0);
    assign m_s      = signed'({1'b0, thr_m});
    assign turn_ext = signed'({{(ddm_pkg::SSIDE_W-SW){turn_s2_reg[SW-1]}}, turn_s2_reg});

    always_comb begin
        if (rev) begin
            left_next  = -m_s - turn_ext;
            right_next = -m_s + turn_ext;
        end else begin
            left_next  = m_s + turn_ext;
            right_next = m_s - turn_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_s3_reg  <= left_next;
            right_s3_reg <= right_next;
        end
    end

    // stage 4: direction, magnitudes, limit check
    logic [ddm_pkg::SIDE_W-1:0] lmag;
    logic [ddm_pkg::SIDE_W-1:0] rmag;
    logic [ddm_pkg::SIDE_W-1:0] top;
    logic                       left_big;
    ddm_pkg::side_t             side_next;
    ddm_pkg::side_t             side_s4_reg;
    logic [ddm_pkg::SIDE_W-1:0] top_s4_reg;
    logic [ddm_pkg::SIDE_W-1:0] small_s4_reg;

    assign lmag     = ddm_pkg::SIDE_W'(left_s3_reg[ddm_pkg::SIDE_W] ? -left_s3_reg : left_s3_reg);
    assign rmag     = ddm_pkg::SIDE_W'(right_s3_reg[ddm_pkg::SIDE_W] ? -right_s3_reg : right_s3_reg);
    assign left_big = lmag > rmag;
    assign top      = left_big ? lmag : rmag;

    always_comb begin
        side_next.lfwd     = !left_s3_reg[ddm_pkg::SIDE_W];
        side_next.rfwd     = !right_s3_reg[ddm_pkg::SIDE_W];
        side_next.lmag     = lmag[ddm_pkg::OUT_MAG_W-1:0];
        side_next.rmag     = rmag[ddm_pkg::OUT_MAG_W-1:0];
        side_next.scale    = top > ddm_pkg::SIDE_W'(limit_reg);
        side_next.left_big = left_big;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_s4_reg  <= side_next;
            top_s4_reg   <= top;
            small_s4_reg <= left_big ? rmag : lmag;
        end
    end

    // stage 5: smaller side times limit
    ddm_pkg::side_t              side_s5_reg;
    logic [ddm_pkg::SIDE_W-1:0]  top_s5_reg;
    logic [ddm_pkg::SPROD_W-1:0] sprod_s5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_s5_reg  <= side_s4_reg;
            top_s5_reg   <= top_s4_reg;
            sprod_s5_reg <= ddm_pkg::SPROD_W'(small_s4_reg) * ddm_pkg::SPROD_W'(limit_reg);
        end
    end

    // stage 6: rounding numerator and divisor
    logic [ddm_pkg::NUM_W-1:0] num;
    ddm_pkg::side_t            side_div_reg [DS+1];
    logic [ddm_pkg::REM_W-1:0] rem_reg      [DS+1];
    logic [ddm_pkg::Q_W-1:0]   lo_reg       [DS+1];
    logic [ddm_pkg::REM_W-1:0] den_reg      [DS+1];

    assign num = {1'b0, sprod_s5_reg, 1'b0} + ddm_pkg::NUM_W'(top_s5_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_div_reg[0] <= side_s5_reg;
            rem_reg[0]      <= num[ddm_pkg::Q_W +: ddm_pkg::REM_W];
            lo_reg[0]       <= num[ddm_pkg::Q_W-1:0];
            den_reg[0]      <= {top_s5_reg, 1'b0};
        end
    end

    // restoring divider, quotient bits shift into the low word
    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [ddm_pkg::REM_W-1:0] rem_next;
        logic [ddm_pkg::Q_W-1:0]   lo_next;

        always_comb begin
            logic [ddm_pkg::REM_W:0] trial;
            rem_next = rem_reg[k];
            lo_next  = lo_reg[k];
            for (int b = 0; b < ddm_pkg::BITS_PER_STAGE; b++) begin
                trial = {rem_next, lo_next[ddm_pkg::Q_W-1]};
                if (trial >= {1'b0, den_reg[k]}) begin
                    rem_next = ddm_pkg::REM_W'(trial - {1'b0, den_reg[k]});
                    lo_next  = {lo_next[ddm_pkg::Q_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[ddm_pkg::REM_W-1:0];
                    lo_next  = {lo_next[ddm_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_div_reg[k+1] <= side_div_reg[k];
                rem_reg[k+1]      <= rem_next;
                lo_reg[k+1]       <= lo_next;
                den_reg[k+1]      <= den_reg[k];
            end
        end
    end

    // output stage
    ddm_pkg::side_t               side_fin;
    logic [ddm_pkg::OUT_MAG_W-1:0] quot;
    logic [ddm_pkg::OUT_MAG_W-1:0] lim;
    logic [ddm_pkg::OUT_MAG_W-1:0] lout_next;
    logic [ddm_pkg::OUT_MAG_W-1:0] rout_next;
    logic [ddm_pkg::OUT_TDATA_W-1:0] out_reg;

    assign side_fin = side_div_reg[DS];
    assign quot     = ddm_pkg::OUT_MAG_W'(lo_reg[DS]);
    assign lim      = ddm_pkg::OUT_MAG_W'(limit_reg);

    always_comb begin
        if (side_fin.scale) begin
            lout_next = side_fin.left_big ? lim : quot;
            rout_next = side_fin.left_big ? quot : lim;
        end else begin
            lout_next = side_fin.lmag;
            rout_next = side_fin.rmag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= ddm_pkg::OUT_TDATA_W'({side_fin.rfwd, side_fin.lfwd, rout_next, lout_next});
        end
    end

    assign m_tdata = out_reg;

    // rem_reg of the last stage is the final remainder, unused beyond the divider
    logic unused_rem;
    assign unused_rem = ^rem_reg[DS] ^ ^den_reg[DS] ^ ^s_tdata[ddm_pkg::IN_TDATA_W-1:2*SW]
                        ^ ^cfg_data;

endmodule

@@ sim/differential_drive_mixer_checker.sv @@
`timescale 1ns / 1ps

module differential_drive_mixer_checker
    import ddm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     outstanding
);

    localparam int CENTRE = 2 ** (STICK_WIDTH - 1);

    // same bit order as m_tdata, lowest field last
    typedef struct packed {
        logic                 rfwd;
        logic                 lfwd;
        logic [OUT_MAG_W-1:0] rmag;
        logic [OUT_MAG_W-1:0] lmag;
    } drive_t;

    logic [DEADBAND_W-1:0] thr_deadband;
    logic [DEADBAND_W-1:0] turn_deadband;
    logic [GAIN_W-1:0]     thr_gain;
    logic [OFFSET_W-1:0]   thr_offset;
    logic [LIMIT_W-1:0]    speed_limit;

    drive_t pending_drive[$];
    drive_t want;
    drive_t got;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // round half up: (side * limit * 2 + peak) / (2 * peak)
    function automatic int limit_scale(input int side, input int peak);
        longint num;
        num = longint'(side) * longint'(speed_limit) * 2 + longint'(peak);
        return int'(num / (longint'(peak) * 2));
    endfunction

    function automatic drive_t mix_sample(input logic [STICK_WIDTH-1:0] turn_pos,
                                          input logic [STICK_WIDTH-1:0] thr_pos);
        int     turn;
        int     thr;
        int     boost;
        int     left;
        int     right;
        int     lmag;
        int     rmag;
        int     peak;
        drive_t d;
        turn = int'(turn_pos) - CENTRE;
        thr  = int'(thr_pos) - CENTRE;
        if (magnitude(thr) < int'(thr_deadband)) thr = 0;
        if (magnitude(turn) < int'(turn_deadband)) turn = 0;
        if (thr != 0) begin
            boost = (magnitude(thr) * int'(thr_gain)) / 10 + int'(thr_offset);
            thr   = (thr > 0) ? boost : -boost;
        end
        if (thr >= 0) begin
            left  = thr + turn;
            right = thr - turn;
        end else begin
            left  = thr - turn;
            right = thr + turn;
        end
        d.lfwd = (left >= 0);
        d.rfwd = (right >= 0);
        lmag   = magnitude(left);
        rmag   = magnitude(right);
        peak   = (lmag > rmag) ? lmag : rmag;
        if (peak > int'(speed_limit)) begin
            lmag = limit_scale(lmag, peak);
            rmag = limit_scale(rmag, peak);
        end
        d.lmag = lmag[OUT_MAG_W-1:0];
        d.rmag = rmag[OUT_MAG_W-1:0];
        return d;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s expected %0d actual %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_deadband  = RST_THROTTLE_DEADBAND;
            turn_deadband = RST_TURN_DEADBAND;
            thr_gain      = RST_THROTTLE_GAIN;
            thr_offset    = RST_THROTTLE_OFFSET;
            speed_limit   = RST_SPEED_LIMIT;
            pending_drive.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_drive.size() == 0) begin
                    $error("result transfer with no sample pending, data %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_drive.pop_front();
                    got  = drive_t'(m_tdata[OUT_BITS-1:0]);
                    check_field("left_magnitude", int'(want.lmag), int'(got.lmag));
                    check_field("right_magnitude", int'(want.rmag), int'(got.rmag));
                    check_field("left_forward", int'(want.lfwd), int'(got.lfwd));
                    check_field("right_forward", int'(want.rfwd), int'(got.rfwd));
                end
            end
            if (s_tvalid && s_tready) begin
                pending_drive.push_back(mix_sample(s_tdata[STICK_WIDTH-1:0],
                                                   s_tdata[2*STICK_WIDTH-1:STICK_WIDTH]));
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_THROTTLE_DEADBAND: thr_deadband  = cfg_data[DEADBAND_W-1:0];
                    CFG_TURN_DEADBAND:     turn_deadband = cfg_data[DEADBAND_W-1:0];
                    CFG_THROTTLE_GAIN:     thr_gain      = cfg_data[GAIN_W-1:0];
                    CFG_THROTTLE_OFFSET:   thr_offset    = cfg_data[OFFSET_W-1:0];
                    CFG_SPEED_LIMIT:       speed_limit   = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_drive.size();
    end

endmodule

@@ sim/differential_drive_mixer_tb.sv @@
`timescale 1ns / 1ps

module differential_drive_mixer_tb
    import ddm_pkg::*;
;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 20;
    localparam int STICK_MAX  = 2 ** STICK_WIDTH - 1;
    localparam int CENTRE     = 2 ** (STICK_WIDTH - 1);

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // turn_position, throttle_position, zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // left_magnitude, right_magnitude, left_forward, right_forward
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int idle_cycles;
    bit tx_burst;
    bit rx_burst;

    differential_drive_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    differential_drive_mixer_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [STICK_WIDTH-1:0] pick_stick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return STICK_WIDTH'($urandom_range(0, STICK_MAX));
        if (r < 85) return STICK_WIDTH'(CENTRE - 40 + int'($urandom_range(0, 80)));
        if (r < 92) return STICK_WIDTH'($urandom_range(0, 8));
        return STICK_WIDTH'(STICK_MAX - int'($urandom_range(0, 8)));
    endfunction

    task automatic send_sample(input int turn, input int thr);
        logic [STICK_WIDTH-1:0] t;
        logic [STICK_WIDTH-1:0] p;
        int                     gap;
        t   = STICK_WIDTH'(turn);
        p   = STICK_WIDTH'(thr);
        gap = gap_len(tx_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, p, t};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(int'(pick_stick()), int'(pick_stick()));
    endtask

    // hold off the sender until every pending result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic program_regs(input int thr_db, input int turn_db, input int gain,
                                input int offset, input int speed);
        logic [CFG_INDEX_W-1:0] idx[5];
        int                     val[5];
        idx = '{CFG_THROTTLE_DEADBAND, CFG_TURN_DEADBAND, CFG_THROTTLE_GAIN,
                CFG_THROTTLE_OFFSET, CFG_SPEED_LIMIT};
        val = '{thr_db, turn_db, gain, offset, speed};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i][CFG_DATA_W-1:0];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic program_random();
        int db;
        int tdb;
        int speed;
        db    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 60);
        tdb   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 60);
        speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(200, 700);
        program_regs(db, tdb, $urandom_range(0, 15), $urandom_range(0, 511), speed);
    endtask

    initial begin
        int hold;
        m_tready = 1'b0;
        hold     = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = gap_len(rx_burst);
                if (m_tready && hold > 0) begin
                    m_tready <= 1'b0;
                    hold--;
                end else begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(0, 15);
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults: corners, deadband edges, one side exactly zero
        send_sample(512, 512);
        send_sample(0, 0);
        send_sample(1023, 1023);
        send_sample(0, 1023);
        send_sample(1023, 0);
        send_sample(512, 1023);
        send_sample(512, 0);
        send_sample(1023, 512);
        send_sample(0, 512);
        send_sample(512, 531);
        send_sample(512, 532);
        send_sample(512, 493);
        send_sample(512, 492);
        send_sample(521, 600);
        send_sample(522, 600);
        send_sample(502, 600);
        send_sample(732, 612);
        send_sample(732, 412);
        send_random(250);

        // everything passes through, widest limit, no idling
        settle();
        program_regs(0, 0, 10, 0, 1023);
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        send_random(200);

        // upper bits set, gain above ten, speed limit zero
        settle();
        program_regs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 0);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        send_sample(0, 0);
        send_sample(1023, 1023);
        send_sample(0, 1023);
        send_sample(1023, 0);
        send_sample(512, 512);
        send_random(150);

        // equal sides above the limit, zero gain
        settle();
        program_regs(30, 5, 0, 300, 100);
        send_sample(512, 1023);
        send_sample(512, 0);
        send_sample(600, 1023);
        send_random(200);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            program_random();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            send_random(160);
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
